@@ sv/ppr_pkg.sv @@
// ----------------------------------------------------------------------------
// ppr_pkg: shared types and helpers for the pixel to premultiplied RGBA unit
// Register indexes, channel payload structs, byte pick and 8x8 alpha scale.
// ----------------------------------------------------------------------------
package ppr_pkg;

    localparam logic [15:0] ROUND_BIAS = 16'd128;
    localparam logic [7:0]  ALPHA_FULL = 8'hFF;
    localparam logic [7:0]  ALPHA_NONE = 8'h00;

    localparam logic [2:0]  PIX_SIZE_RGBA = 3'd4;
    localparam logic [2:0]  PIX_SIZE_RGB  = 3'd3;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_PIXEL_SIZE   = 3'd0,
        CFG_RED_OFFSET   = 3'd1,
        CFG_GREEN_OFFSET = 3'd2,
        CFG_BLUE_OFFSET  = 3'd3,
        CFG_ALPHA_OFFSET = 3'd4,
        CFG_PREMULTIPLY  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0] pixel_size;
        logic [1:0] red_offset;
        logic [1:0] green_offset;
        logic [1:0] blue_offset;
        logic [1:0] alpha_offset;
        logic       premultiply;
    } t_cfg;

    typedef struct packed {
        t_cfg_idx   reg_index;
        logic [2:0] wr_data;
    } t_cfg_wr;

    typedef struct packed {
        logic [31:0] pixel_bytes;
        logic        first_of_picture;
        logic        last_of_picture;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       any_clear;
        logic       any_partial;
        logic       colours_premultiplied;
        logic       end_of_picture;
    } t_rgba_out;

    // per-pixel classification handed from the converter to the flag logic
    typedef struct packed {
        logic is_clear;
        logic is_partial;
        logic is_premult;
    } t_pix_class;

    function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = word[7:0];
            2'd1:    b = word[15:8];
            2'd2:    b = word[23:16];
            default: b = word[31:24];
        endcase
        return b;
    endfunction

    // round(c * a / 255): t = c*a + 128, result = (t + (t >> 8)) >> 8
    function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] c);
        logic [15:0] t;
        logic [16:0] s;
        t = (16'(a) * 16'(c)) + ROUND_BIAS;
        s = {1'b0, t} + 17'(t[15:8]);
        return s[15:8];
    endfunction

endpackage

@@ sv/ppr_chan_if.sv @@
// ----------------------------------------------------------------------------
// ppr_chan_if: valid/ready channel
// Carries one payload of a configurable struct type per transfer.
// ----------------------------------------------------------------------------
interface ppr_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/photo_pixel_to_premultiplied_rgba_unit.sv @@
// A pixel taken in passes the input register, then the result register, before it shows on o_rgba.
// Throughput: one pixel per cycle; the input register and the result register
// each advance whenever the stage after them is empty or drains in the same cycle.
// Reset (synchronous, i_rst_n low): both stages empty, sticky picture flags
// cleared, configuration back to rgba layout r/g/b/a at bytes 0..3, premultiply on.
// Configuration writes are taken every cycle (i_cfg.ready is always high).
// ----------------------------------------------------------------------------
// photo_pixel_to_premultiplied_rgba_unit: source pixel to premultiplied RGBA
// Two-register pipeline: input register, byte select and alpha scale, result
// register; sticky clear/partial/premultiplied flags per picture.
// ----------------------------------------------------------------------------
module photo_pixel_to_premultiplied_rgba_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppr_chan_if.sink   i_pix,
    ppr_chan_if.source o_rgba,
    ppr_chan_if.sink   i_cfg
);
    import ppr_pkg::*;

    // configuration registers
    t_cfg       r_cfg;

    // input stage
    logic       r_s1_valid;
    t_pix_in    r_s1;

    // result stage
    logic       r_out_valid;
    t_rgba_out  r_out;
    t_rgba_out  n_out;

    // sticky picture flags, state after the last pixel that left the input stage
    logic       r_clear_seen;
    logic       r_partial_seen;
    logic       r_premult_seen;

    // handshake and converter signals
    logic       s2_ready;
    logic       s1_advance;
    logic       in_xfer;
    logic [7:0] cv_red;
    logic [7:0] cv_green;
    logic [7:0] cv_blue;
    logic [7:0] cv_alpha;
    t_pix_class cv_class;
    logic       base_clear;
    logic       base_partial;
    logic       base_premult;

    // ------------------------------------------------------------------
    // Handshake: the result register takes a new pixel when it is empty or
    // its current pixel transfers out this cycle; the input register then
    // frees up the same way, so a full pipeline keeps moving at one per cycle while o_rgba.ready holds.
    // ------------------------------------------------------------------
    assign s2_ready     = !r_out_valid || o_rgba.ready;
    assign s1_advance   = r_s1_valid && s2_ready;
    assign i_pix.ready  = !r_s1_valid || s2_ready;
    assign in_xfer      = i_pix.valid && i_pix.ready;

    assign i_cfg.ready  = 1'b1;

    assign o_rgba.valid = r_out_valid;
    assign o_rgba.data  = r_out;

    // ------------------------------------------------------------------
    // Byte select and premultiply on the registered pixel
    // ------------------------------------------------------------------
    ppr_convert u_convert (
        .i_cfg         (r_cfg),
        .i_pixel_bytes (r_s1.pixel_bytes),
        .o_red         (cv_red),
        .o_green       (cv_green),
        .o_blue        (cv_blue),
        .o_alpha       (cv_alpha),
        .o_class       (cv_class)
    );

    // ------------------------------------------------------------------
    // Sticky flags: the first pixel of a picture starts from clear flags,
    // then this pixel's classification is merged in. The result carries the
    // flags including the current pixel.
    // ------------------------------------------------------------------
    assign base_clear   = r_clear_seen   && !r_s1.first_of_picture;
    assign base_partial = r_partial_seen && !r_s1.first_of_picture;
    assign base_premult = r_premult_seen && !r_s1.first_of_picture;

    always_comb begin
        n_out.red                   = cv_red;
        n_out.green                 = cv_green;
        n_out.blue                  = cv_blue;
        n_out.alpha                 = cv_alpha;
        n_out.any_clear             = base_clear   || cv_class.is_clear;
        n_out.any_partial           = base_partial || cv_class.is_partial;
        n_out.colours_premultiplied = base_premult || cv_class.is_premult;
        n_out.end_of_picture        = r_s1.last_of_picture;
    end

    // ------------------------------------------------------------------
    // Configuration registers: indexes past the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_size   <= PIX_SIZE_RGBA;
            r_cfg.red_offset   <= 2'd0;
            r_cfg.green_offset <= 2'd1;
            r_cfg.blue_offset  <= 2'd2;
            r_cfg.alpha_offset <= 2'd3;
            r_cfg.premultiply  <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.reg_index)
                CFG_PIXEL_SIZE:   r_cfg.pixel_size   <= i_cfg.data.wr_data;
                CFG_RED_OFFSET:   r_cfg.red_offset   <= i_cfg.data.wr_data[1:0];
                CFG_GREEN_OFFSET: r_cfg.green_offset <= i_cfg.data.wr_data[1:0];
                CFG_BLUE_OFFSET:  r_cfg.blue_offset  <= i_cfg.data.wr_data[1:0];
                CFG_ALPHA_OFFSET: r_cfg.alpha_offset <= i_cfg.data.wr_data[1:0];
                CFG_PREMULTIPLY:  r_cfg.premultiply  <= i_cfg.data.wr_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input stage: load on every input transfer, drop the valid bit when the
    // pixel moves on with nothing behind it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= i_pix.data;
        end
    end

    // ------------------------------------------------------------------
    // Result stage and sticky flags: advance together so the flags follow
    // pixel order exactly
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_clear_seen   <= 1'b0;
            r_partial_seen <= 1'b0;
            r_premult_seen <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid    <= 1'b1;
            r_clear_seen   <= n_out.any_clear;
            r_partial_seen <= n_out.any_partial;
            r_premult_seen <= n_out.colours_premultiplied;
        end else if (o_rgba.ready) begin
            r_out_valid    <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // a premultiplied pixel is always a partial one
    a_premult_implies_partial: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_rgba.valid |-> (!o_rgba.data.colours_premultiplied || o_rgba.data.any_partial)
    ) else $error("premultiplied flag set without partial flag");

    // the premultiplied flag only rises while premultiply is enabled
    a_premult_needs_enable: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_premult_seen) |-> $past(r_cfg.premultiply)
    ) else $error("premultiplied flag rose with premultiply off");

    // input back-pressure only when both registers hold a pixel
    a_stall_only_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_s1_valid && r_out_valid && !o_rgba.ready)
    ) else $error("input stalled with room in the pipeline");

    // a waiting result is neither lost nor overwritten
    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rgba.ready) |=> (r_out_valid && $stable(r_out))
    ) else $error("pending result changed before transfer");

endmodule

@@ sv/ppr_convert.sv @@
// ----------------------------------------------------------------------------
// ppr_convert: pixel byte select and alpha premultiply
// Picks colour and alpha bytes by offset and scales partial rgba pixels when premultiply is on.
// ----------------------------------------------------------------------------
module ppr_convert (
    input  ppr_pkg::t_cfg       i_cfg,
    input  logic [31:0]         i_pixel_bytes,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_alpha,
    output ppr_pkg::t_pix_class o_class
);
    import ppr_pkg::*;

    logic [7:0] red_raw;
    logic [7:0] green_raw;
    logic [7:0] blue_raw;
    logic [7:0] alpha_raw;
    logic       is_rgba;

    assign red_raw   = pick_byte(i_pixel_bytes, i_cfg.red_offset);
    assign green_raw = pick_byte(i_pixel_bytes, i_cfg.green_offset);
    assign blue_raw  = pick_byte(i_pixel_bytes, i_cfg.blue_offset);
    assign alpha_raw = pick_byte(i_pixel_bytes, i_cfg.alpha_offset);
    assign is_rgba   = (i_cfg.pixel_size == PIX_SIZE_RGBA);

    always_comb begin
        o_class.is_clear   = is_rgba && (alpha_raw == ALPHA_NONE);
        o_class.is_partial = is_rgba && (alpha_raw != ALPHA_NONE)
                             && (alpha_raw != ALPHA_FULL);
        o_class.is_premult = o_class.is_partial && i_cfg.premultiply;
    end

    always_comb begin
        case (i_cfg.pixel_size)
            PIX_SIZE_RGBA: begin
                o_alpha = alpha_raw;
                if (o_class.is_premult) begin
                    o_red   = scale8(alpha_raw, red_raw);
                    o_green = scale8(alpha_raw, green_raw);
                    o_blue  = scale8(alpha_raw, blue_raw);
                end else begin
                    o_red   = red_raw;
                    o_green = green_raw;
                    o_blue  = blue_raw;
                end
            end
            PIX_SIZE_RGB: begin
                o_red   = red_raw;
                o_green = green_raw;
                o_blue  = blue_raw;
                o_alpha = ALPHA_FULL;
            end
            default: begin
                // gray: the red byte fills all three colours
                o_red   = red_raw;
                o_green = red_raw;
                o_blue  = red_raw;
                o_alpha = ALPHA_FULL;
            end
        endcase
    end

endmodule
